>>> rtl/i2c_sensor_register_file_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor register file
// Concurrent assertion shorthands clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_SENSOR_REGISTER_FILE_MACROS_SVH
`define I2C_SENSOR_REGISTER_FILE_MACROS_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define ISRF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isrf assertion failed");

// Next-cycle implication: when the antecedent holds, the consequent holds in the next cycle.
`define ISRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isrf assertion failed");

`endif

>>> rtl/isrf_pkg.sv
// ----------------------------------------------------------------------------
// Sensor register file package
// Shared opcodes, register addresses, reset values and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isrf_pkg;

  // Bus operations carried by one request.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } cmd_t;

  localparam logic [7:0] ADDR_CTRL1   = 8'h10;
  localparam logic [7:0] ADDR_CTRL5   = 8'h14;
  localparam logic [7:0] ADDR_STATUS  = 8'h25;
  localparam logic [7:0] ADDR_Z_LOW   = 8'h2c;
  localparam logic [7:0] ADDR_Z_HIGH  = ADDR_Z_LOW + 8'h01;
  localparam logic [7:0] ADDR_IDENT   = 8'h43;
  localparam logic [7:0] IDENT_VALUE  = 8'h45;
  localparam logic [7:0] Z_HIGH_VALUE = 8'h40;
  localparam int unsigned SOFT_RESET_BIT = 5;
  localparam logic [7:0] RATE_MASK    = 8'hf0;
  localparam logic [7:0] READY_FLAG   = 8'h01;

  // Power-on contents of a register.
  function automatic logic [7:0] reset_value(input logic [7:0] addr);
    logic [7:0] val;
    val = 8'h00;
    if (addr == ADDR_IDENT) begin
      val = IDENT_VALUE;
    end else if (addr == ADDR_Z_HIGH) begin
      val = Z_HIGH_VALUE;
    end
    return val;
  endfunction

endpackage

>>> rtl/isrf_ctrl.sv
// ----------------------------------------------------------------------------
// Sensor register file controller
// Sequences one request through execute and response cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isrf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output isrf_pkg::cmd_t cmd_o
);
  import isrf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    busy          = 1'b0;
    done_o        = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.respond = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy       = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        // The response is registered, so a new request may enter now.
        done_o        = 1'b1;
        cmd_o.respond = 1'b1;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/isrf_datapath.sv
// ----------------------------------------------------------------------------
// Sensor register file datapath
// Register memory with valid bits, pointer, pending flag and read response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isrf_datapath #(
  parameter int unsigned REG_COUNT = 96
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  isrf_pkg::cmd_t cmd_i,
  input  logic [1:0]     op_i,
  input  logic [7:0]     data_i,
  output logic [7:0]     read_data_o
);
  import isrf_pkg::*;

  localparam int unsigned AW = $clog2(REG_COUNT);

  op_e         op_q;
  logic [7:0]  data_q;
  logic [7:0]  ptr_q;
  logic        pend_q;
  logic        rate_q;
  logic [REG_COUNT-1:0] vld_q;
  logic [7:0]  mem [REG_COUNT];

  logic [7:0]  mem_q;
  logic [7:0]  dflt_q;
  logic        hit_q;
  logic        sel_q;
  logic        ready_q;

  logic [AW-1:0] idx;
  logic          in_range;
  logic          wr_ok;
  logic          soft_rst;
  logic          wr_en;
  logic [7:0]    rd_val;

  assign idx      = ptr_q[AW-1:0];
  assign in_range = ({1'b0, ptr_q} < 9'(REG_COUNT));
  assign wr_ok    = cmd_i.exec && (op_q == OP_WRITE) && !pend_q && in_range;
  assign soft_rst = wr_ok && (ptr_q == ADDR_CTRL1) && data_q[SOFT_RESET_BIT];
  assign wr_en    = wr_ok && !soft_rst && (ptr_q != ADDR_IDENT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      data_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= 8'h00;
      pend_q <= 1'b1;
    end else if (cmd_i.exec) begin
      case (op_q)
        OP_START: begin
          pend_q <= 1'b1;
        end
        OP_WRITE: begin
          if (pend_q) begin
            ptr_q  <= data_q;
            pend_q <= 1'b0;
          end else if (in_range) begin
            ptr_q <= ptr_q + 8'd1;
          end
        end
        OP_READ: begin
          ptr_q <= ptr_q + 8'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Valid bits: an entry that was never written since the last reset reads
  // as its power-on value. The rate flag mirrors control register 5.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rate_q <= 1'b0;
    end else if (soft_rst) begin
      vld_q  <= '0;
      rate_q <= 1'b0;
    end else if (wr_en) begin
      vld_q[idx] <= 1'b1;
      if (ptr_q == ADDR_CTRL5) begin
        rate_q <= |(data_q & RATE_MASK);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (op_q == OP_READ) && in_range) begin
      mem_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      sel_q   <= (op_q == OP_READ) && in_range;
      hit_q   <= in_range && vld_q[idx];
      dflt_q  <= reset_value(ptr_q);
      ready_q <= (ptr_q == ADDR_STATUS) && rate_q;
    end
  end

  always_comb begin
    rd_val = hit_q ? mem_q : dflt_q;
    if (ready_q) begin
      rd_val = rd_val | READY_FLAG;
    end
    read_data_o = (cmd_i.respond && sel_q) ? rd_val : 8'h00;
  end

endmodule

>>> rtl/i2c_sensor_register_file.sv
// ----------------------------------------------------------------------------
// I2C sensor register file
// Byte register file with auto-incrementing pointer for an accelerometer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request, of
// any kind, produces exactly one response, which follows its execute cycle:
// done_o is high for one cycle with read_data_o, which carries the register
// byte for a read and zero otherwise. The receiver cannot stall, so the
// response must be captured in that cycle. The execute cycle holds busy high;
// in the response cycle busy is low again, so a new request can be taken in
// the response cycle but not in the execute cycle. A start-of-write request
// makes the next written byte load the pointer; later written bytes store to
// the addressed register and advance the pointer while it is below REG_COUNT.
// Reads always advance the pointer with 8-bit wrap and return zero beyond
// REG_COUNT. The identity register ignores writes, setting the soft-reset bit
// of control register 1 restores the power-on contents through per-entry
// valid bits, and the status register reports data-ready while the rate
// field of control register 5 is nonzero. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_sensor_register_file #(
  parameter int unsigned REG_COUNT = 96
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op_i,
  input  logic [7:0] data_i,
  output logic       done_o,
  output logic [7:0] read_data_o
);
  import isrf_pkg::*;

  // Commands from the sequencer to the register datapath.
  cmd_t cmd;

  isrf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  isrf_datapath #(
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (op_i),
    .data_i      (data_i),
    .read_data_o (read_data_o)
  );

endmodule

>>> rtl/isrf_checker.sv
// ----------------------------------------------------------------------------
// Sensor register file checker
// Port-level timing checks of the request and response sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_sensor_register_file_macros.svh"

module isrf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] op_i,
  input logic       done_o,
  input logic [7:0] read_data_o
);
  import isrf_pkg::*;

  `ISRF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ISRF_ASSERT_NEXT(a_busy_done, busy, done_o && !busy)
  `ISRF_ASSERT_SAME(a_done_after_busy, done_o, $past(busy))
  `ISRF_ASSERT_NEXT(a_nonread_zero, start && !busy && (op_i != OP_READ), ##1 (read_data_o == 8'h00))

endmodule

bind i2c_sensor_register_file isrf_checker u_isrf_checker (.*);
